[rtl/core/cusr_pkg.sv]
`timescale 1ns / 1ps
package cusr_pkg;

    localparam int MAX_PAYLOAD = 480;
    localparam int HDR_LEN     = 9;
    localparam int PKT_LIMIT   = HDR_LEN + MAX_PAYLOAD;
    localparam int BANK_DEPTH  = 2 * MAX_PAYLOAD;
    localparam int ADDR_W      = $clog2(BANK_DEPTH);
    localparam int CNT_W       = $clog2(PKT_LIMIT + 2);
    localparam int LEN_W       = 9;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic [31:0] MODEL_SIZE_RST = 32'd2177224;
    localparam logic [31:0] TIMEOUT_RST    = 32'd900000;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_VERIFY = 2'd2;

    localparam logic [7:0] OP_BEGIN  = 8'd1;
    localparam logic [7:0] OP_CHUNK  = 8'd2;
    localparam logic [7:0] OP_END    = 8'd3;
    localparam logic [7:0] OP_CANCEL = 8'd5;
    localparam logic [7:0] OP_RESUME = 8'd6;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_COMMIT = 3'd2;
    localparam logic [2:0] ACT_ABORT  = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    localparam logic [2:0] ST_AVAIL  = 3'd0;
    localparam logic [2:0] ST_RECV   = 3'd1;
    localparam logic [2:0] ST_VERIFY = 3'd2;
    localparam logic [2:0] ST_INST   = 3'd3;
    localparam logic [2:0] ST_FAILED = 3'd4;

    localparam logic [3:0] ERR_OK      = 4'd0;
    localparam logic [3:0] ERR_IO      = 4'd4;
    localparam logic [3:0] ERR_OFFSET  = 4'd5;
    localparam logic [3:0] ERR_CANCEL  = 4'd7;
    localparam logic [3:0] ERR_TIMEOUT = 4'd8;
    localparam logic [3:0] ERR_BADPKT  = 4'd9;

    localparam logic CFG_MODEL_SIZE = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    typedef enum logic [4:0] {
        PH_AVAIL  = 5'b00001,
        PH_RECV   = 5'b00010,
        PH_VERIFY = 5'b00100,
        PH_INST   = 5'b01000,
        PH_FAILED = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic        end_of_packet;
        logic [31:0] connection_id;
        logic [31:0] now_time;
        logic [3:0]  backend_status;
        logic        write_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  upload_state;
        logic [3:0]  error_code;
        logic [31:0] session_id;
        logic [31:0] write_offset;
        logic        chunk_bank;
        logic [8:0]  chunk_length;
    } out_item_t;

    // One classified event handed from the front to the back.
    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] n;
        logic [7:0]       op;
        logic [31:0]      id;
        logic [31:0]      at;
        logic [31:0]      conn;
        logic [31:0]      now;
        logic [3:0]       status;
        logic             wok;
        logic             same;
    } event_t;

    typedef struct packed {
        logic [31:0] model_size;
        logic [31:0] timeout_ticks;
    } cfg_t;

    function automatic logic [3:0] clamp_status(input logic [3:0] s);
        return (s > 4'd9) ? ERR_IO : s;
    endfunction

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        c = ST_AVAIL;
        unique case (p)
            PH_AVAIL:  c = ST_AVAIL;
            PH_RECV:   c = ST_RECV;
            PH_VERIFY: c = ST_VERIFY;
            PH_INST:   c = ST_INST;
            PH_FAILED: c = ST_FAILED;
            default:   c = ST_AVAIL;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/cusr_queue.sv]
`timescale 1ns / 1ps
module cusr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cusr_pkg::event_t push_ev,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output cusr_pkg::event_t head
);
    import cusr_pkg::*;

    event_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == Q_DEPTH[Q_PTR_W:0]);
    assign nonempty = (cnt_reg != '0);
    assign head     = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{Q_PTR_W{1'b0}}, push} - {{Q_PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_ev;
        end
    end
endmodule

[rtl/core/cusr_front.sv]
`timescale 1ns / 1ps
module cusr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cusr_pkg::in_item_t s_data,
    input  logic               prev_bank,
    input  logic               pkt_done,
    input  logic               q_full,
    output logic               push,
    output cusr_pkg::event_t   push_ev,
    output logic               pend_final
);
    import cusr_pkg::*;

    logic [7:0]       bank_mem [BANK_DEPTH];
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       rdata_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next, n_sat;
    logic             same_reg, same_next;
    logic             pend_reg, pend_next;

    logic             a_valid_reg, a_valid_next;
    in_item_t         a_item_reg;
    logic [CNT_W-1:0] a_n_reg;
    logic             a_inpay_reg;

    logic             accept, adv, a_push, eq_now, is_byte;
    logic [ADDR_W-1:0] pos, rd_addr, wr_addr;

    assign is_byte = (s_data.req_type == REQ_BYTE);
    assign a_push  = a_valid_reg && (a_item_reg.req_type == REQ_TICK
                  || a_item_reg.req_type == REQ_VERIFY
                  || (a_item_reg.req_type == REQ_BYTE && a_item_reg.end_of_packet));
    assign adv     = !a_valid_reg || !a_push || !q_full;
    // A new packet byte waits until the back has settled the bank of the last packet.
    assign s_ready = adv && (!is_byte || !pend_reg);
    assign accept  = s_valid && s_ready;
    assign push    = a_push && !q_full;
    assign pend_final = pend_reg;

    assign n_sat   = (cnt_reg <= CNT_W'(PKT_LIMIT)) ? cnt_reg + 1'b1 : cnt_reg;
    assign pos     = ADDR_W'(cnt_reg - CNT_W'(HDR_LEN));
    assign rd_addr = prev_bank ? pos + ADDR_W'(MAX_PAYLOAD) : pos;
    assign wr_addr = prev_bank ? pos : pos + ADDR_W'(MAX_PAYLOAD);
    assign eq_now  = same_reg && !(a_inpay_reg && rdata_reg != a_item_reg.data_byte);

    always_comb begin
        push_ev.kind   = a_item_reg.req_type;
        push_ev.n      = a_n_reg;
        push_ev.op     = hdr_reg[0];
        push_ev.id     = {hdr_reg[4], hdr_reg[3], hdr_reg[2], hdr_reg[1]};
        push_ev.at     = {hdr_reg[8], hdr_reg[7], hdr_reg[6], hdr_reg[5]};
        push_ev.conn   = a_item_reg.connection_id;
        push_ev.now    = a_item_reg.now_time;
        push_ev.status = clamp_status(a_item_reg.backend_status);
        push_ev.wok    = a_item_reg.write_ok;
        push_ev.same   = eq_now;
    end

    always_comb begin
        cnt_next     = cnt_reg;
        same_next    = same_reg;
        pend_next    = pend_reg;
        a_valid_next = a_valid_reg;
        if (accept && is_byte) begin
            cnt_next = s_data.end_of_packet ? '0 : n_sat;
        end
        if (adv && a_valid_reg && a_item_reg.req_type == REQ_BYTE) begin
            same_next = a_item_reg.end_of_packet ? 1'b1 : eq_now;
        end
        if (pkt_done) begin
            pend_next = 1'b0;
        end
        if (accept && is_byte && s_data.end_of_packet) begin
            pend_next = 1'b1;
        end
        if (adv) begin
            a_valid_next = accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            same_reg    <= 1'b1;
            pend_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            same_reg    <= same_next;
            pend_reg    <= pend_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_item_reg  <= s_data;
            a_n_reg     <= n_sat;
            a_inpay_reg <= is_byte && cnt_reg >= CNT_W'(HDR_LEN)
                        && cnt_reg < CNT_W'(PKT_LIMIT);
        end
        if (accept && is_byte && cnt_reg < CNT_W'(HDR_LEN)) begin
            hdr_reg[cnt_reg[3:0]] <= s_data.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_byte && cnt_reg >= CNT_W'(HDR_LEN)
                && cnt_reg < CNT_W'(PKT_LIMIT)) begin
            bank_mem[wr_addr] <= s_data.data_byte;
            rdata_reg         <= bank_mem[rd_addr];
        end
    end
endmodule

[rtl/core/cusr_back.sv]
`timescale 1ns / 1ps
module cusr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  cusr_pkg::cfg_t      cfg,
    input  logic                q_nonempty,
    input  cusr_pkg::event_t    ev,
    output logic                pop,
    output logic                pkt_done,
    output logic                prev_bank,
    output logic                m_valid,
    input  logic                m_ready,
    output cusr_pkg::out_item_t m_data
);
    import cusr_pkg::*;

    phase_t      ph_reg, ph_next;
    logic [3:0]  err_reg, err_next;
    logic [31:0] sess_reg, sess_next, acc_reg, acc_next, own_reg, own_next;
    logic [31:0] la_reg, la_next, pco_reg, pco_next;
    logic [LEN_W-1:0] pcl_reg, pcl_next;
    logic        pb_reg, pb_next;
    logic        mv_reg, mv_next;
    out_item_t   out_reg, out_next;

    logic [2:0]       act;
    logic             obank;
    logic [LEN_W-1:0] olen, size;
    logic             busy, short_n;

    assign pop       = q_nonempty && (!mv_reg || m_ready);
    assign pkt_done  = pop && ev.kind == REQ_BYTE;
    assign prev_bank = pb_reg;
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;
    assign busy      = (ph_reg == PH_RECV) || (ph_reg == PH_VERIFY);
    assign short_n   = (ev.n == CNT_W'(5));
    assign size      = LEN_W'(ev.n - CNT_W'(HDR_LEN));

    always_comb begin
        ph_next = ph_reg; err_next = err_reg; sess_next = sess_reg; acc_next = acc_reg;
        own_next = own_reg; la_next = la_reg; pco_next = pco_reg; pcl_next = pcl_reg;
        pb_next = pb_reg;
        act = ACT_NONE; obank = 1'b0; olen = '0;
        if (ev.kind == REQ_TICK) begin
            if (busy && (ev.now - la_reg) > cfg.timeout_ticks) begin
                ph_next = PH_FAILED; err_next = ERR_TIMEOUT; pcl_next = '0; act = ACT_ABORT;
            end
        end else if (ev.kind == REQ_VERIFY) begin
            if (ph_reg == PH_VERIFY) begin
                if (ev.status != ERR_OK) begin
                    ph_next = PH_FAILED; err_next = ev.status; pcl_next = '0; act = ACT_ABORT;
                end else begin
                    ph_next = PH_INST; err_next = ERR_OK; act = ACT_FINISH;
                end
            end
        end else begin
            priority if (ev.n < CNT_W'(5) || ev.n > CNT_W'(PKT_LIMIT) || ev.id == '0) begin
                act = ACT_NONE;
            end else if (ev.op == OP_BEGIN && short_n && !busy) begin
                sess_next = ev.id; acc_next = '0; err_next = ev.status; pcl_next = '0;
                act = ACT_START;
                if (ev.status != ERR_OK) begin
                    ph_next = PH_FAILED;
                end else begin
                    ph_next = PH_RECV; own_next = ev.conn; la_next = ev.now;
                end
            end else if (ev.id != sess_reg) begin
                act = ACT_NONE;
            end else if (ev.op == OP_RESUME && short_n && busy) begin
                own_next = ev.conn; la_next = ev.now;
            end else if (!busy || own_reg != ev.conn) begin
                act = ACT_NONE;
            end else if (ev.op == OP_CANCEL && short_n) begin
                ph_next = PH_FAILED; err_next = ERR_CANCEL; pcl_next = '0; act = ACT_ABORT;
            end else if (ev.op == OP_BEGIN && short_n) begin
                la_next = ev.now;
            end else if (ev.op == OP_CHUNK && ph_reg == PH_RECV
                         && ev.n > CNT_W'(HDR_LEN)) begin
                // An exact repeat of the last committed chunk is dropped quietly.
                if (pcl_reg == size && ev.at == pco_reg && ev.same) begin
                    la_next = ev.now;
                end else if (ev.at != acc_reg || acc_reg > cfg.model_size
                             || {23'd0, size} > cfg.model_size - acc_reg) begin
                    ph_next = PH_FAILED; err_next = ERR_OFFSET; pcl_next = '0;
                    act = ACT_ABORT;
                end else if (!ev.wok) begin
                    ph_next = PH_FAILED; err_next = ERR_IO; pcl_next = '0; act = ACT_ABORT;
                end else begin
                    pb_next = !pb_reg; pco_next = ev.at; pcl_next = size;
                    acc_next = acc_reg + {23'd0, size}; la_next = ev.now;
                    act = ACT_COMMIT; obank = !pb_reg; olen = size;
                end
            end else if (ev.op == OP_END && short_n && ph_reg == PH_RECV
                         && acc_reg == cfg.model_size) begin
                ph_next = PH_VERIFY; la_next = ev.now;
            end else begin
                ph_next = PH_FAILED; err_next = ERR_BADPKT; pcl_next = '0; act = ACT_ABORT;
            end
        end
        out_next.action       = act;
        out_next.upload_state = phase_code(ph_next);
        out_next.error_code   = err_next;
        out_next.session_id   = sess_next;
        out_next.write_offset = acc_next;
        out_next.chunk_bank   = obank;
        out_next.chunk_length = olen;
        mv_next = pop ? 1'b1 : (m_ready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_AVAIL; err_reg <= ERR_OK; sess_reg <= '0; acc_reg <= '0;
            own_reg <= '0; la_reg <= '0; pco_reg <= '0; pcl_reg <= '0; pb_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            mv_reg <= mv_next;
            if (pop) begin
                ph_reg <= ph_next; err_reg <= err_next; sess_reg <= sess_next;
                acc_reg <= acc_next; own_reg <= own_next; la_reg <= la_next;
                pco_reg <= pco_next; pcl_reg <= pcl_next; pb_reg <= pb_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end
endmodule

[rtl/core/chunked_upload_session_receiver_unit.sv]
`timescale 1ns / 1ps
// Result path: a final packet byte, tick or verify beat puts its result on m_data through
// the front register, an event queue entry and the back output register; other
// bytes give none.
// Throughput: one beat per cycle while the event queue has room; after a final byte the
// next packet byte waits until the back has chosen the payload bank, and later
// still while queued events or a result held by m_ready keep the back busy.
// Reset: synchronous active-low aresetn clears the session state and event queue; the
// configuration registers return to their defaults; payload banks are not cleared.
module chunked_upload_session_receiver_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cusr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cusr_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import cusr_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   push, q_full, q_nonempty, pop, pkt_done, prev_bank, pend_final;
    event_t push_ev, head;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_index[7:1] == '0) begin
            if (cfg_index[0] == CFG_MODEL_SIZE) begin
                cfg_next.model_size = cfg_data;
            end else begin
                cfg_next.timeout_ticks = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.model_size    <= MODEL_SIZE_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cusr_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .prev_bank(prev_bank), .pkt_done(pkt_done), .q_full(q_full),
        .push(push), .push_ev(push_ev), .pend_final(pend_final)
    );

    cusr_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_ev(push_ev), .full(q_full),
        .pop(pop), .nonempty(q_nonempty), .head(head)
    );

    cusr_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_nonempty(q_nonempty), .ev(head),
        .pop(pop), .pkt_done(pkt_done), .prev_bank(prev_bank), .m_valid(m_valid),
        .m_ready(m_ready), .m_data(m_data)
    );

    a_commit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == ACT_COMMIT |-> m_data.chunk_length != '0)
        else $error("commit without payload");
    a_noncommit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != ACT_COMMIT |-> m_data.chunk_length == '0
        && !m_data.chunk_bank)
        else $error("bank or length on a result that is not a commit");
    a_bank_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == REQ_BYTE |-> !pend_final)
        else $error("packet byte taken before the bank was settled");
    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == ACT_START |-> m_data.upload_state == ST_RECV
        || m_data.upload_state == ST_FAILED)
        else $error("start reported in a wrong state");
endmodule
